[hdl/cca_pkg.sv]
// Shared types and constants for the cumulative channel average block.
// No dependencies; compile first.
`default_nettype none

package cca_pkg;

    localparam int CHANNELS   = 512;   // sum memory depth
    localparam int COUNT_BITS = 16;    // frame counter width (divisor width)

    localparam int ADDR_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W       = 9;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 32;
    localparam int AVG_W      = 16;
    localparam int FRAMES_W   = 16;
    localparam int CFG_W      = 10;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(512);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_DIV,
        ST_FINISH
    } cca_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [SUM_W-1:0]  data;
    } mem_wr_t;

    typedef struct packed {
        logic                  start;
        logic [SUM_W-1:0]      dividend;   // magnitude
        logic [COUNT_BITS-1:0] divisor;    // never zero
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;        // magnitude
    } div_rsp_t;

endpackage

`default_nettype wire

[hdl/cca_sum_mem.sv]
// Per-channel running sum memory: one write port, one registered read port.
// Depends on cca_pkg.
`default_nettype none

module cca_sum_mem (
    input  wire logic                        aclk,
    input  wire cca_pkg::mem_wr_t            wr,
    input  wire logic [cca_pkg::ADDR_W-1:0]  rd_addr,
    output logic      [cca_pkg::SUM_W-1:0]   rd_data
);
    import cca_pkg::*;

    logic [SUM_W-1:0] mem [CHANNELS];

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hdl/cca_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on cca_pkg.
`default_nettype none

module cca_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cca_pkg::div_req_t req,
    output cca_pkg::div_rsp_t      rsp
);
    import cca_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [SUM_W-1:0]      quo_reg,  quo_next;
    logic [COUNT_BITS-1:0] rem_reg,  rem_next;
    logic [COUNT_BITS-1:0] div_reg,  div_next;

    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    always_comb begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        diff      = trial - {1'b0, div_reg};
        ge        = (trial >= {1'b0, div_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            quo_next = {quo_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[hdl/cumulative_channel_average_top.sv]
// Top level of the per-channel cumulative average block.
// Depends on cca_pkg, cca_sum_mem and cca_divider.
//
// Each input word carries one Q8.8 sample for one channel; the block adds it
// to that channel's 32-bit saturating running sum and returns the sum divided
// by the frame count (current frame included), truncated toward zero and
// clamped to 16 bits. Each word passes through a memory read, a
// read-modify-write, then 32 steps of the shared one-bit-per-cycle divider;
// no new word is taken until its result is loaded. A word with the clear flag
// first sweeps all CHANNELS (512) sum entries to zero, one entry per cycle.
// The same sweep runs right after reset, with s_tready low. The result sits
// in an output register, so the next word can be taken while a result still
// waits on m_tready. channels_in_use must be written through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce this.
`default_nettype none

module cumulative_channel_average_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration: channels_in_use
    input  wire logic                          cfg_wr_en,
    input  wire logic [cca_pkg::CFG_W-1:0]     cfg_wr_data,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cca_pkg::S_TDATA_W-1:0] s_tdata,  // [8:0] channel, [24:9] sample, zeros
    input  wire logic                          s_tuser,  // [0] clear
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [cca_pkg::M_TDATA_W-1:0] m_tdata,  // [15:0] average, [31:16] frames_seen
    output logic                               m_tuser   // [0] frame count saturated
);
    import cca_pkg::*;

    cca_state_t state_reg, state_next;

    // captured word
    logic [CH_W-1:0]            ch_reg;
    logic signed [SAMPLE_W-1:0] smp_reg;
    logic                       clr_item_reg, clr_item_next;

    logic [CFG_W-1:0]           chans_reg;
    logic [COUNT_BITS-1:0]      fcount_reg, fcount_next;
    logic [COUNT_BITS-1:0]      n_reg,      n_next;
    logic [ADDR_W-1:0]          sweep_reg,  sweep_next;
    logic                       ch_ok_reg,  ch_ok_next;
    logic                       neg_reg,    neg_next;

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic [AVG_W-1:0]           m_avg_reg,   m_avg_next;
    logic [FRAMES_W-1:0]        m_frm_reg,   m_frm_next;
    logic                       m_sat_reg,   m_sat_next;

    mem_wr_t                    mem_wr;
    logic [SUM_W-1:0]           rd_data;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    logic                       accept;
    logic [SUM_W:0]             sum_wide;
    logic [SUM_W-1:0]           sum_sat;
    logic [SUM_W-1:0]           sum_mag;
    logic [COUNT_BITS-1:0]      n_cur;
    logic [31:0]                last_ch;
    logic                       ch_ok;
    logic                       load_out;
    logic [AVG_W-1:0]           avg_val;

    cca_sum_mem u_mem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_addr (ADDR_W'(ch_reg)),
        .rd_data (rd_data)
    );

    cca_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_item_reg <= 1'b0;
            chans_reg    <= CFG_RESET;
            fcount_reg   <= '0;
            sweep_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_item_reg <= clr_item_next;
            fcount_reg   <= fcount_next;
            sweep_reg    <= sweep_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                chans_reg <= cfg_wr_data;
            end
        end
        if (accept) begin
            ch_reg  <= s_tdata[CH_W-1:0];
            smp_reg <= s_tdata[CH_W +: SAMPLE_W];
        end
        n_reg     <= n_next;
        ch_ok_reg <= ch_ok_next;
        neg_reg   <= neg_next;
        m_avg_reg <= m_avg_next;
        m_frm_reg <= m_frm_next;
        m_sat_reg <= m_sat_next;
    end

    // datapath pieces used by the sequencer
    always_comb begin
        sum_wide = {rd_data[SUM_W-1], rd_data}
                 + {{(SUM_W + 1 - SAMPLE_W){smp_reg[SAMPLE_W-1]}}, smp_reg};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            // clamp to the signed 32-bit limits
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        sum_mag = sum_sat[SUM_W-1] ? (~sum_sat + 1'b1) : sum_sat;

        // frames including this one, held once the counter is full
        n_cur = (&fcount_reg) ? fcount_reg : fcount_reg + 1'b1;

        // effective last channel, register clamped to 1..CHANNELS
        if (chans_reg == '0) begin
            last_ch = 32'd0;
        end else if (32'(chans_reg) > 32'(CHANNELS)) begin
            last_ch = 32'(CHANNELS - 1);
        end else begin
            last_ch = 32'(chans_reg) - 32'd1;
        end

        ch_ok = (32'(ch_reg) < 32'(CHANNELS));

        // quotient magnitude back to signed Q8.8 with saturation
        if (!neg_reg) begin
            avg_val = (div_rsp.quotient > SUM_W'(32767)) ? 16'h7FFF
                                                         : div_rsp.quotient[AVG_W-1:0];
        end else begin
            avg_val = (div_rsp.quotient > SUM_W'(32768)) ? 16'h8000
                                                         : (~div_rsp.quotient[AVG_W-1:0] + 1'b1);
        end
    end

    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_item_next = clr_item_reg;
        fcount_next   = fcount_reg;
        sweep_next    = sweep_reg;
        n_next        = n_reg;
        ch_ok_next    = ch_ok_reg;
        neg_next      = neg_reg;
        s_tready      = 1'b0;

        mem_wr.we     = 1'b0;
        mem_wr.addr   = ADDR_W'(ch_reg);
        mem_wr.data   = sum_sat;

        div_req.start    = 1'b0;
        div_req.dividend = sum_mag;
        div_req.divisor  = n_cur;

        m_valid_next = m_valid_reg;
        m_avg_next   = m_avg_reg;
        m_frm_next   = m_frm_reg;
        m_sat_next   = m_sat_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                // zero one sum per cycle; count restarts too
                fcount_next = '0;
                mem_wr.we   = 1'b1;
                mem_wr.addr = sweep_reg;
                mem_wr.data = '0;
                if (sweep_reg == ADDR_W'(CHANNELS - 1)) begin
                    sweep_next = '0;
                    state_next = clr_item_reg ? ST_READ : ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    clr_item_next = s_tuser;
                    sweep_next    = '0;
                    state_next    = s_tuser ? ST_CLEAR : ST_READ;
                end
            end
            ST_READ: begin
                // memory read of ch_reg is in flight
                state_next = ST_ADD;
            end
            ST_ADD: begin
                n_next     = n_cur;
                ch_ok_next = ch_ok;
                neg_next   = sum_sat[SUM_W-1];
                if (ch_ok) begin
                    mem_wr.we     = 1'b1;
                    div_req.start = 1'b1;
                    if (32'(ch_reg) == last_ch) begin
                        fcount_next = n_cur;
                    end
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    m_avg_next   = ch_ok_reg ? avg_val : '0;
                    m_frm_next   = (32'(n_reg) > 32'hFFFF) ? 16'hFFFF : FRAMES_W'(n_reg);
                    m_sat_next   = &n_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_frm_reg, m_avg_reg};
    assign m_tuser  = m_sat_reg;

`ifndef SYNTHESIS
    // divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider done outside ST_DIV");

    // sums are written only by the sweep or the read-modify-write of a valid channel
    a_mem_wr_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr.we |-> ((state_reg == ST_CLEAR) || ((state_reg == ST_ADD) && ch_ok)))
        else $error("unexpected sum memory write");

    // frame count moves only in the sweep or when a word is summed
    a_fcount_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg != ST_ADD) && (state_reg != ST_CLEAR)) |=> $stable(fcount_reg))
        else $error("frame count changed outside update");

    // an accepted word always leaves idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("ready stayed high after accept");
`endif

endmodule

`default_nettype wire
